/* rtl/tor_pkg.sv */
// ----------------------------------------------------------------------------
// tor_pkg: shared types and codes for the telnet receive negotiator
// Telnet command bytes, option codes, result kinds and the result record.
// ----------------------------------------------------------------------------
package tor_pkg;

    // telnet command bytes
    localparam logic [7:0] CMD_SE   = 8'd240;
    localparam logic [7:0] CMD_SB   = 8'd250;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_DONT = 8'd254;
    localparam logic [7:0] CMD_IAC  = 8'd255;

    // option codes
    localparam logic [7:0] OPT_BINARY        = 8'd0;
    localparam logic [7:0] OPT_ECHO          = 8'd1;
    localparam logic [7:0] OPT_SGA           = 8'd3;
    localparam logic [7:0] OPT_TIMING_MARK   = 8'd6;
    localparam logic [7:0] OPT_TERMINAL_TYPE = 8'd24;
    localparam logic [7:0] OPT_EOR           = 8'd25;
    localparam logic [7:0] OPT_NEW_ENVIRON   = 8'd39;
    localparam logic [7:0] OPT_START_TLS     = 8'd46;

    // result kinds
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_REPLY   = 3'd1;
    localparam logic [2:0] KIND_TTYPE   = 3'd2;
    localparam logic [2:0] KIND_ENVIRON = 3'd3;
    localparam logic [2:0] KIND_TLS     = 3'd4;

    // one result transaction
    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] data_byte;
        logic [7:0] reply_verb;
        logic [7:0] reply_option;
        logic       binary_agreed;
        logic       eor_agreed;
    } result_t;

endpackage

/* rtl/tor_parser.sv */
// ----------------------------------------------------------------------------
// tor_parser: telnet command parser and option negotiator
// Decodes one registered byte per step, keeps the parse state and the
// binary / eor agreements, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module tor_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output tor_pkg::result_t  res
);
    import tor_pkg::*;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_IAC    = 2'd1;
    localparam logic [1:0] PH_VERB   = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_cmd_reg, held_cmd_next;
    logic       in_sub_reg, in_sub_next;
    logic [7:0] sub_opt_reg, sub_opt_next;
    logic       bin_reg, bin_next;
    logic       eor_reg, eor_next;

    logic       hit;
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] verb;
    logic [7:0] opt;

    always_comb
    begin
        phase_next    = PH_NORMAL;
        held_cmd_next = held_cmd_reg;
        in_sub_next   = in_sub_reg;
        sub_opt_next  = sub_opt_reg;
        bin_next      = bin_reg;
        eor_next      = eor_reg;
        hit  = 1'b0;
        kind = KIND_DATA;
        data = 8'd0;
        verb = 8'd0;
        opt  = 8'd0;

        case (phase_reg)
            PH_IAC:
            begin
                if (rx_byte == CMD_IAC)
                begin
                    // escaped 255 is swallowed inside a subnegotiation
                    if (!in_sub_reg)
                    begin
                        hit  = 1'b1;
                        data = CMD_IAC;
                    end
                end
                else if (rx_byte >= CMD_SB && rx_byte <= CMD_DONT)
                begin
                    held_cmd_next = rx_byte;
                    phase_next    = PH_VERB;
                end
                else if (rx_byte == CMD_SE && in_sub_reg)
                begin
                    in_sub_next = 1'b0;
                    if (sub_opt_reg == OPT_TERMINAL_TYPE)
                    begin
                        hit  = 1'b1;
                        kind = KIND_TTYPE;
                    end
                    else if (sub_opt_reg == OPT_NEW_ENVIRON)
                    begin
                        hit  = 1'b1;
                        kind = KIND_ENVIRON;
                    end
                end
            end
            PH_VERB:
            begin
                if (held_cmd_reg == CMD_WILL)
                begin
                    hit  = 1'b1;
                    kind = KIND_REPLY;
                    opt  = rx_byte;
                    if (rx_byte == OPT_BINARY || rx_byte == OPT_EOR ||
                        rx_byte == OPT_ECHO || rx_byte == OPT_SGA)
                    begin
                        verb = CMD_DO;
                        if (rx_byte == OPT_BINARY)
                            bin_next = 1'b1;
                        if (rx_byte == OPT_EOR)
                            eor_next = 1'b1;
                    end
                    else if (rx_byte == OPT_START_TLS)
                    begin
                        kind = KIND_TLS;
                        opt  = 8'd0;
                    end
                    else
                    begin
                        verb = CMD_DONT;
                    end
                end
                else if (held_cmd_reg == CMD_DO)
                begin
                    hit  = 1'b1;
                    kind = KIND_REPLY;
                    opt  = rx_byte;
                    if (rx_byte == OPT_BINARY || rx_byte == OPT_EOR ||
                        rx_byte == OPT_TERMINAL_TYPE || rx_byte == OPT_NEW_ENVIRON)
                    begin
                        verb = CMD_WILL;
                        if (rx_byte == OPT_BINARY)
                            bin_next = 1'b1;
                        if (rx_byte == OPT_EOR)
                            eor_next = 1'b1;
                    end
                    else
                    begin
                        // timing mark and unknown options both get wont
                        verb = CMD_WONT;
                    end
                end
                else if (held_cmd_reg == CMD_SB)
                begin
                    in_sub_next  = 1'b1;
                    sub_opt_next = rx_byte;
                end
            end
            default:
            begin
                if (rx_byte == CMD_IAC)
                    phase_next = PH_IAC;
                else if (!in_sub_reg)
                begin
                    hit  = 1'b1;
                    data = rx_byte;
                end
            end
        endcase
    end

    assign res_valid         = step && hit;
    assign res.result_kind   = kind;
    assign res.data_byte     = data;
    assign res.reply_verb    = verb;
    assign res.reply_option  = opt;
    assign res.binary_agreed = bin_next;
    assign res.eor_agreed    = eor_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NORMAL;
            held_cmd_reg <= 8'd0;
            in_sub_reg   <= 1'b0;
            sub_opt_reg  <= 8'd0;
            bin_reg      <= 1'b0;
            eor_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            held_cmd_reg <= held_cmd_next;
            in_sub_reg   <= in_sub_next;
            sub_opt_reg  <= sub_opt_next;
            bin_reg      <= bin_next;
            eor_reg      <= eor_next;
        end
    end

    a_bin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        bin_reg |=> bin_reg)
        else $error("binary agreement dropped");

    a_verb_held: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VERB |-> (held_cmd_reg >= CMD_SB && held_cmd_reg <= CMD_DONT))
        else $error("verb phase without a negotiation verb");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.result_kind == KIND_DATA) |->
        (res.reply_verb == 8'd0 && res.reply_option == 8'd0))
        else $error("data transaction carries reply fields");

endmodule

/* rtl/tor_out_buf.sv */
// ----------------------------------------------------------------------------
// tor_out_buf: two-entry result buffer
// Holds finished results for the output stream so the parser keeps taking
// bytes while the consumer stalls, until both entries are full.
// ----------------------------------------------------------------------------
module tor_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tor_pkg::result_t  push_data,
    output logic              ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output tor_pkg::result_t  head
);
    import tor_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign ready         = (count_reg != 2'd2);
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign head          = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == 2'd2))
        else $error("push into full result buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("buffer pointers disagree with count");

endmodule

/* rtl/telnet_rx_option_negotiator.sv */
// ----------------------------------------------------------------------------
// telnet_rx_option_negotiator: telnet receive command parser
// Strips telnet commands from a received byte stream, answers option
// negotiation and reports terminal-type, environment and start-tls requests.
//
//   channel   dir  tdata                                    tuser
//   s_axis    in   [7:0] rx_byte                            -
//   m_axis    out  [7:0] data_byte [15:8] reply_verb         [2:0] result_kind
//                  [23:16] reply_option [24] binary_agreed
//                  [25] eor_agreed [31:26] zero
//
// one byte per cycle while the result buffer has room; a byte that makes a result
// passes the input register, then the result buffer, before it shows on m_axis
// the parse state updates once per byte in a single decode stage
// bytes that make no result are consumed without an output transaction
// input waits while the input register holds a byte and the two-entry result
// buffer is full; under steady traffic each output stall holds up the input
// rst_n clears parse state, agreements and buffer occupancy
// ----------------------------------------------------------------------------
module telnet_rx_option_negotiator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_byte, reply_verb, reply_option,
                                        // binary_agreed, eor_agreed, zero pad
    output logic [2:0]  m_axis_tuser    // result_kind
);
    import tor_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       buf_ready;
    logic       step;
    logic       s_accept;
    logic       res_valid;
    result_t    res;
    result_t    head;

    assign step          = in_valid_reg && buf_ready;
    assign s_axis_tready = !in_valid_reg || buf_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_byte_reg <= s_axis_tdata;
    end

    tor_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tor_out_buf u_out_buf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (res_valid),
        .push_data     (res),
        .ready         (buf_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .head          (head)
    );

    assign m_axis_tuser = head.result_kind;
    assign m_axis_tdata = {6'd0, head.eor_agreed, head.binary_agreed,
                           head.reply_option, head.reply_verb, head.data_byte};

endmodule

/* dv/tor_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tor_checker: result checker for the telnet receive negotiator
// Watches both stream channels, decodes every accepted rx byte with its own
// copy of the parse state and agreements, and compares each output
// transaction field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tor_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [7:0] data_byte, [15:8] reply_verb,
                                        // [23:16] reply_option, [24] binary_agreed,
                                        // [25] eor_agreed, [31:26] zero
    input  logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    output int          error_count,
    output int          pending,
    output int          checked_count,
    output logic [4:0]  kinds_seen
);
    import tor_pkg::*;

    typedef enum logic [1:0] {PH_NORMAL, PH_IAC, PH_VERB} phase_e;

    phase_e     phase;
    logic [7:0] held_verb;
    logic       sub_open;
    logic [7:0] sub_opt;
    logic       bin_ok;
    logic       eor_ok;
    result_t    expected_results[$];

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // agreements are taken after this byte has updated them
    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] data,
                                            input logic [7:0] verb, input logic [7:0] opt);
        result_t r;
        r.result_kind   = kind;
        r.data_byte     = data;
        r.reply_verb    = verb;
        r.reply_option  = opt;
        r.binary_agreed = bin_ok;
        r.eor_agreed    = eor_ok;
        return r;
    endfunction

    task automatic decode_rx_byte(input logic [7:0] b, output bit produced,
                                  output result_t res);
        logic [2:0] kind;
        logic [7:0] verb;
        produced = 1'b0;
        res      = '0;
        kind     = KIND_REPLY;
        verb     = 8'd0;
        case (phase)
            PH_IAC:
            begin
                phase = PH_NORMAL;
                if (b == CMD_IAC)
                begin
                    // escaped 255 is swallowed inside a subnegotiation
                    if (!sub_open)
                    begin
                        produced = 1'b1;
                        res = make_result(KIND_DATA, CMD_IAC, 8'd0, 8'd0);
                    end
                end
                else if (b >= CMD_SB && b <= CMD_DONT)
                begin
                    held_verb = b;
                    phase     = PH_VERB;
                end
                else if (b == CMD_SE && sub_open)
                begin
                    sub_open = 1'b0;
                    if (sub_opt == OPT_TERMINAL_TYPE)
                    begin
                        produced = 1'b1;
                        res = make_result(KIND_TTYPE, 8'd0, 8'd0, 8'd0);
                    end
                    else if (sub_opt == OPT_NEW_ENVIRON)
                    begin
                        produced = 1'b1;
                        res = make_result(KIND_ENVIRON, 8'd0, 8'd0, 8'd0);
                    end
                end
            end
            PH_VERB:
            begin
                phase = PH_NORMAL;
                if (held_verb == CMD_WILL)
                begin
                    produced = 1'b1;
                    verb     = CMD_DO;
                    if (b == OPT_BINARY)
                        bin_ok = 1'b1;
                    else if (b == OPT_EOR)
                        eor_ok = 1'b1;
                    else if (b == OPT_START_TLS)
                        kind = KIND_TLS;
                    else if (b != OPT_ECHO && b != OPT_SGA)
                        verb = CMD_DONT;
                end
                else if (held_verb == CMD_DO)
                begin
                    produced = 1'b1;
                    verb     = CMD_WILL;
                    if (b == OPT_BINARY)
                        bin_ok = 1'b1;
                    else if (b == OPT_EOR)
                        eor_ok = 1'b1;
                    else if (b != OPT_TERMINAL_TYPE && b != OPT_NEW_ENVIRON)
                        verb = CMD_WONT;
                end
                else if (held_verb == CMD_SB)
                begin
                    sub_open = 1'b1;
                    sub_opt  = b;
                end
                if (produced)
                begin
                    if (kind == KIND_TLS)
                        res = make_result(KIND_TLS, 8'd0, 8'd0, 8'd0);
                    else
                        res = make_result(KIND_REPLY, 8'd0, verb, b);
                end
            end
            default:
            begin
                phase = PH_NORMAL;
                if (b == CMD_IAC)
                    phase = PH_IAC;
                else if (!sub_open)
                begin
                    produced = 1'b1;
                    res = make_result(KIND_DATA, b, 8'd0, 8'd0);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bit      produced;
        result_t res;
        result_t want;
        if (!rst_n)
        begin
            phase         = PH_NORMAL;
            held_verb     = 8'd0;
            sub_open      = 1'b0;
            sub_opt       = 8'd0;
            bin_ok        = 1'b0;
            eor_ok        = 1'b0;
            error_count   = 0;
            checked_count = 0;
            kinds_seen    = '0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_error($sformatf("result with nothing pending, kind %0d tdata %h",
                                           m_axis_tuser, m_axis_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", {5'd0, m_axis_tuser}, {5'd0, want.result_kind});
                    check_field("data_byte", m_axis_tdata[7:0], want.data_byte);
                    check_field("reply_verb", m_axis_tdata[15:8], want.reply_verb);
                    check_field("reply_option", m_axis_tdata[23:16], want.reply_option);
                    check_field("binary_agreed", {7'd0, m_axis_tdata[24]},
                                {7'd0, want.binary_agreed});
                    check_field("eor_agreed", {7'd0, m_axis_tdata[25]},
                                {7'd0, want.eor_agreed});
                    check_field("tdata pad", {2'd0, m_axis_tdata[31:26]}, 8'd0);
                    checked_count++;
                    if (want.result_kind <= KIND_TLS)
                        kinds_seen[want.result_kind] = 1'b1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_rx_byte(s_axis_tdata, produced, res);
                if (produced)
                    expected_results.push_back(res);
            end
        end
        pending = expected_results.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the telnet receive negotiator
// Feeds directed command sequences, then random mixes of data, negotiation,
// subnegotiation, standalone commands and noise, with random idle on both
// channels; results are checked by tor_checker.
// ----------------------------------------------------------------------------
module tb_top;

    import tor_pkg::*;

    localparam int RANDOM_BYTES = 900;
    localparam int SEGMENT_BYTES = 120;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;   // [7:0] data_byte, [15:8] reply_verb, [23:16] reply_option,
                                 // [24] binary_agreed, [25] eor_agreed, [31:26] zero
    logic [2:0]  m_axis_tuser;   // [2:0] result_kind

    int          error_count;
    int          pending;
    int          checked_count;
    logic [4:0]  kinds_seen;

    int          bytes_sent = 0;
    int          segments = 0;
    logic        sender_idle = 1'b0;
    logic        sink_stalls = 1'b0;
    int          stall_left = 0;

    telnet_rx_option_negotiator u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tor_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending       (pending),
        .checked_count (checked_count),
        .kinds_seen    (kinds_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short stalls, now and then a long one
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 99) < 30)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // table options most of the time, any byte otherwise
    function automatic logic [7:0] pick_option();
        logic [7:0] table_opts [8];
        table_opts = '{OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_TIMING_MARK,
                       OPT_TERMINAL_TYPE, OPT_EOR, OPT_NEW_ENVIRON, OPT_START_TLS};
        if ($urandom_range(0, 99) < 60)
            return table_opts[3'($urandom_range(0, 7))];
        return 8'($urandom_range(0, 255));
    endfunction

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_random_sequence();
        int r;
        int body;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_byte(8'($urandom_range(0, 254)));
        else if (r < 38)
        begin
            send_byte(CMD_IAC);
            send_byte(CMD_IAC);
        end
        else if (r < 65)
        begin
            send_byte(CMD_IAC);
            send_byte(8'($urandom_range(CMD_SB, CMD_DONT)));
            send_byte(pick_option());
        end
        else if (r < 80)
        begin
            send_byte(CMD_IAC);
            send_byte(CMD_SB);
            r = $urandom_range(0, 9);
            send_byte(r < 4 ? OPT_TERMINAL_TYPE : r < 7 ? OPT_NEW_ENVIRON : pick_option());
            body = $urandom_range(0, 4);
            repeat (body)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_byte(8'($urandom_range(0, 254)));
                else
                begin
                    send_byte(CMD_IAC);
                    if (r < 8)
                        send_byte(CMD_IAC);
                    else
                    begin
                        // negotiation nested in the subnegotiation
                        send_byte(8'($urandom_range(CMD_SB, CMD_DONT)));
                        send_byte(pick_option());
                    end
                end
            end
            if ($urandom_range(0, 99) < 85)
            begin
                send_byte(CMD_IAC);
                send_byte(CMD_SE);
            end
        end
        else if (r < 88)
        begin
            send_byte(CMD_IAC);
            send_byte(8'($urandom_range(0, CMD_SB - 1)));
        end
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        logic [7:0] directed_seq [$];
        int         next_switch;
        bit         paused;
        directed_seq = '{8'h00, 8'h7f,
                         CMD_IAC, CMD_IAC,
                         CMD_IAC, CMD_WILL, OPT_BINARY,
                         CMD_IAC, CMD_DO, OPT_EOR,
                         CMD_IAC, CMD_WILL, OPT_START_TLS,
                         CMD_IAC, CMD_DO, OPT_TIMING_MARK,
                         CMD_IAC, CMD_WONT, 8'hff,
                         CMD_IAC, CMD_SB, OPT_TERMINAL_TYPE, 8'h41,
                         CMD_IAC, CMD_IAC,
                         CMD_IAC, CMD_SE,
                         CMD_IAC, CMD_SE,
                         CMD_IAC, 8'hf1};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sink_stalls <= 1'b1;
        sender_idle <= 1'b1;
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);
        wait_drained();

        // first segment runs with no idle on either side
        sink_stalls <= 1'b0;
        sender_idle <= 1'b0;
        next_switch = bytes_sent + SEGMENT_BYTES;
        paused = 1'b0;
        while (bytes_sent < directed_seq.size() + RANDOM_BYTES)
        begin
            send_random_sequence();
            if (bytes_sent >= next_switch)
            begin
                segments++;
                next_switch = bytes_sent + SEGMENT_BYTES;
                if (!paused && bytes_sent >= directed_seq.size() + RANDOM_BYTES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                sink_stalls <= $urandom_range(0, 3) != 0;
                sender_idle <= $urandom_range(0, 3) != 0;
            end
        end
        wait_drained();
        repeat (10) @(negedge clk);

        $display("%0d rx bytes over %0d idle settings, %0d results checked",
                 bytes_sent, segments + 2, checked_count);
        $display("result kinds seen (bit per kind): %b", kinds_seen);
        if (error_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAILURE");
        $finish;
    end

endmodule
